>>> rtl/request_netstring_deframer_core_defines.svh
// Assertion macros shared by the checker of the request deframer core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef REQUEST_NETSTRING_DEFRAMER_CORE_DEFINES_SVH
`define REQUEST_NETSTRING_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RND_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("request deframer check failed");

// Next-cycle implication, checked outside reset.
`define RND_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("request deframer check failed");

`endif

>>> rtl/rnd_pkg.sv
// Types and constants of the request deframer core.
// No dependencies; the output interface, parser, skid register, top level and checker import it.
package rnd_pkg;

  localparam int CONN_W    = 31;
  localparam int OUT_LEN_W = 24;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  typedef enum logic [3:0] {
    FLD_ID   = 4'd0,
    FLD_CONN = 4'd1,
    FLD_PATH = 4'd2,
    FLD_HLEN = 4'd3,
    FLD_HDR  = 4'd4,
    FLD_SKIP = 4'd5,
    FLD_BLEN = 4'd6,
    FLD_BODY = 4'd7,
    FLD_IGN  = 4'd8
  } field_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_OVF   = 2'd2,
    ST_NOLEN = 2'd3
  } status_t;

  typedef struct packed {
    field_t                 field;
    logic [7:0]             byte_out;
    logic                   payload_valid;
    logic                   field_end;
    logic [CONN_W-1:0]      conn_num;
    logic [OUT_LEN_W-1:0]   header_length;
    logic [OUT_LEN_W-1:0]   body_length;
    status_t                status;
    logic                   message_end;
  } result_t;

endpackage

>>> rtl/rnd_in_if.sv
// Input channel of the request deframer: one request byte per beat.
// Depends on nothing but the valid/ready handshake it carries.
interface rnd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, end_of_message, output ready);
endinterface

>>> rtl/rnd_out_if.sv
// Output channel of the request deframer: one tagged byte per beat.
// The connection number and length widths come from rnd_pkg.
interface rnd_out_if import rnd_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [3:0]           field;
  logic [7:0]           byte_out;
  logic                 payload_valid;
  logic                 field_end;
  logic [CONN_W-1:0]    conn_num;
  logic [OUT_LEN_W-1:0] header_length;
  logic [OUT_LEN_W-1:0] body_length;
  logic [1:0]           status;
  logic                 message_end;

  modport source (output valid, field, byte_out, payload_valid, field_end, conn_num,
                  header_length, body_length, status, message_end, input ready);
  modport sink   (input valid, field, byte_out, payload_valid, field_end, conn_num,
                  header_length, body_length, status, message_end, output ready);
endinterface

>>> rtl/rnd_parser.sv
// Input register, parse state and next-state logic of the request deframer.
// Uses rnd_pkg for field codes, status codes and the result struct.
module rnd_parser import rnd_pkg::*; #(
  parameter int LEN_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eom,
  output logic       res_valid,
  output result_t    res,
  input  logic       res_space
);

  localparam int EXT_W = (LEN_BITS > OUT_LEN_W) ? LEN_BITS : OUT_LEN_W;
  localparam logic [EXT_W-1:0] OUT_MAX_EXT = EXT_W'({OUT_LEN_W{1'b1}});

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eom;
  logic       advance;

  // Parse state.
  field_t              phase, phase_next;
  logic [LEN_BITS-1:0] remaining, remaining_next;
  logic [CONN_W-1:0]   conn_acc, conn_acc_next;
  logic                conn_done, conn_done_next;
  logic [LEN_BITS-1:0] hlen, hlen_next;
  logic [LEN_BITS-1:0] blen, blen_next;
  status_t             err, err_next;
  logic                len_seen, len_seen_next;
  logic                len_done, len_done_next;

  // Datapath helpers.
  logic                is_digit;
  logic [3:0]          digit;
  logic [LEN_BITS-1:0] len_src;
  logic [LEN_BITS+3:0] len_prod;
  logic                len_ovf;
  logic [LEN_BITS-1:0] len_sat;
  logic [CONN_W+3:0]   conn_prod;
  logic [CONN_W-1:0]   conn_sat;
  logic [LEN_BITS-1:0] rem_dec;
  logic                pv, fe;
  logic [EXT_W-1:0]    hlen_ext, blen_ext;

  assign advance   = s1_valid && res_space;
  assign in_ready  = !s1_valid || res_space;
  assign res_valid = s1_valid;

  assign is_digit = (s1_byte inside {[8'h30:8'h39]});
  assign digit    = s1_byte[3:0];

  // One shared multiply-by-ten for whichever length is being read.
  assign len_src  = (phase == FLD_BLEN) ? blen : hlen;
  assign len_prod = ({4'b0, len_src} << 3) + ({4'b0, len_src} << 1)
                  + {{LEN_BITS{1'b0}}, digit};
  assign len_ovf  = |len_prod[LEN_BITS+3:LEN_BITS];
  assign len_sat  = len_ovf ? {LEN_BITS{1'b1}} : len_prod[LEN_BITS-1:0];

  assign conn_prod = ({4'b0, conn_acc} << 3) + ({4'b0, conn_acc} << 1)
                   + {{CONN_W{1'b0}}, digit};
  assign conn_sat  = (|conn_prod[CONN_W+3:CONN_W]) ? {CONN_W{1'b1}}
                                                   : conn_prod[CONN_W-1:0];

  assign rem_dec = (remaining == '0) ? '0 : remaining - 1'b1;

  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    conn_acc_next  = conn_acc;
    conn_done_next = conn_done;
    hlen_next      = hlen;
    blen_next      = blen;
    err_next       = err;
    len_seen_next  = len_seen;
    len_done_next  = len_done;
    pv             = 1'b1;
    fe             = 1'b0;

    case (phase)
      FLD_ID, FLD_PATH: begin
        if (s1_byte == CHAR_SPACE) begin
          pv = 1'b0;
          fe = 1'b1;
          phase_next = (phase == FLD_ID) ? FLD_CONN : FLD_HLEN;
        end
      end
      FLD_CONN: begin
        if (s1_byte == CHAR_SPACE) begin
          pv = 1'b0;
          fe = 1'b1;
          phase_next = FLD_PATH;
        end else if (!conn_done) begin
          if (is_digit) conn_acc_next = conn_sat;
          else          conn_done_next = 1'b1;
        end
      end
      FLD_HLEN, FLD_BLEN: begin
        if (s1_byte == CHAR_COLON) begin
          pv = 1'b0;
          fe = 1'b1;
          if (!len_seen && err_next == ST_OK) err_next = ST_NOLEN;
          len_seen_next = 1'b0;
          len_done_next = 1'b0;
          remaining_next = len_src;
          if (phase == FLD_HLEN) phase_next = (len_src == '0) ? FLD_SKIP : FLD_HDR;
          else                   phase_next = (len_src == '0) ? FLD_IGN : FLD_BODY;
        end else if (!len_done) begin
          if (!is_digit) begin
            len_done_next = 1'b1;
          end else begin
            len_seen_next = 1'b1;
            if (phase == FLD_HLEN) hlen_next = len_sat;
            else                   blen_next = len_sat;
            if (len_ovf && err_next == ST_OK) err_next = ST_OVF;
          end
        end
      end
      FLD_HDR, FLD_BODY: begin
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          fe = 1'b1;
          phase_next = (phase == FLD_HDR) ? FLD_SKIP : FLD_IGN;
        end
      end
      FLD_SKIP: begin
        pv = 1'b0;
        fe = 1'b1;
        phase_next = FLD_BLEN;
      end
      default: begin
        pv = 1'b0;
      end
    endcase

    // A message that ends before its body is complete is truncated.
    if (s1_eom && (phase_next < FLD_IGN) && err_next == ST_OK) err_next = ST_TRUNC;
  end

  assign hlen_ext = EXT_W'(hlen_next);
  assign blen_ext = EXT_W'(blen_next);

  always_comb begin
    res.field         = phase;
    res.byte_out      = s1_byte;
    res.payload_valid = pv;
    res.field_end     = fe;
    res.conn_num      = conn_acc_next;
    res.header_length = (hlen_ext > OUT_MAX_EXT) ? {OUT_LEN_W{1'b1}} : hlen_ext[OUT_LEN_W-1:0];
    res.body_length   = (blen_ext > OUT_MAX_EXT) ? {OUT_LEN_W{1'b1}} : blen_ext[OUT_LEN_W-1:0];
    res.status        = err_next;
    res.message_end   = s1_eom;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
      s1_eom  <= in_eom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && s1_eom)) begin
      phase     <= FLD_ID;
      remaining <= '0;
      conn_acc  <= '0;
      conn_done <= 1'b0;
      hlen      <= '0;
      blen      <= '0;
      err       <= ST_OK;
      len_seen  <= 1'b0;
      len_done  <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      conn_acc  <= conn_acc_next;
      conn_done <= conn_done_next;
      hlen      <= hlen_next;
      blen      <= blen_next;
      err       <= err_next;
      len_seen  <= len_seen_next;
      len_done  <= len_done_next;
    end
  end

endmodule

>>> rtl/rnd_skid.sv
// Result register with one skid entry for the request deframer output.
// Uses rnd_pkg for the result struct.
module rnd_skid import rnd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  input  result_t push_data,
  output logic    push_ready,
  output logic    pop_valid,
  output result_t pop_data,
  input  logic    pop_ready
);

  logic    skid_valid;
  result_t skid_data;
  logic    push;
  logic    load_out;

  assign push_ready = !skid_valid;
  assign push       = push_valid && push_ready;
  assign load_out   = !pop_valid || pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      pop_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
    if (load_out) begin
      pop_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> rtl/request_netstring_deframer_core.sv
// Top level of the request deframer core: parser plus output skid register.
// Depends on rnd_pkg, rnd_in_if, rnd_out_if, rnd_parser and rnd_skid.
//
//   Channel     Direction  Beat content
//   in_stream   sink       data_byte, end_of_message
//   out_stream  source     field, byte_out, payload_valid, field_end, conn_num,
//                          header_length, body_length, status, message_end
//
// Every accepted byte yields exactly one output beat; one byte per clock is sustained while the output is ready.
// From input beat to output valid a byte passes one input register, then one
// result register, with the parse logic between them.
// Reset is synchronous on rst and clears the handshake and parse state at once.
// A stalled output fills the skid entry first; input ready drops only when both
// output entries and the input register hold pending work.
module request_netstring_deframer_core import rnd_pkg::*; #(
  parameter int LEN_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  rnd_in_if.sink    in_stream,
  rnd_out_if.source out_stream
);

  // Parser to skid register: the parsed beat and its handshake.
  logic    res_valid;
  logic    res_space;
  result_t res;
  result_t out_data;

  // The parser holds the input register and all message state. It advances a byte
  // only when the skid stage can take the result, so the state never runs ahead.
  rnd_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .in_byte   (in_stream.data_byte),
    .in_eom    (in_stream.end_of_message),
    .res_valid (res_valid),
    .res       (res),
    .res_space (res_space)
  );

  // The result register decouples the downstream ready from the parser.
  rnd_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (res_space),
    .pop_valid  (out_stream.valid),
    .pop_data   (out_data),
    .pop_ready  (out_stream.ready)
  );

  // Unpack the registered result onto the output channel.
  assign out_stream.field         = out_data.field;
  assign out_stream.byte_out      = out_data.byte_out;
  assign out_stream.payload_valid = out_data.payload_valid;
  assign out_stream.field_end     = out_data.field_end;
  assign out_stream.conn_num      = out_data.conn_num;
  assign out_stream.header_length = out_data.header_length;
  assign out_stream.body_length   = out_data.body_length;
  assign out_stream.status        = out_data.status;
  assign out_stream.message_end   = out_data.message_end;

endmodule

>>> rtl/rnd_checker.sv
// Port-level checks on the request deframer core, attached by a bind statement.
// Depends on rnd_pkg and request_netstring_deframer_core_defines.svh.
`include "request_netstring_deframer_core_defines.svh"

module rnd_checker import rnd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] field,
  input logic [7:0] byte_out,
  input logic       payload_valid,
  input logic       field_end
);

  // Ignored bytes carry neither content nor a field end.
  `RND_ASSERT_NOW(ign_is_inert, out_valid && field == FLD_IGN, !payload_valid && !field_end)
  // The skipped byte always closes its field without content.
  `RND_ASSERT_NOW(skip_closes, out_valid && field == FLD_SKIP, !payload_valid && field_end)
  // Content that ends a field occurs only on the last header or body byte.
  `RND_ASSERT_NOW(content_end_counted, out_valid && payload_valid && field_end,
                  field == FLD_HDR || field == FLD_BODY)
  // A stalled result stays on the port unchanged.
  `RND_ASSERT_NEXT(stall_holds, out_valid && !out_ready, out_valid && $stable(byte_out))

endmodule

bind request_netstring_deframer_core rnd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_stream.valid),
  .out_ready     (out_stream.ready),
  .field         (out_stream.field),
  .byte_out      (out_stream.byte_out),
  .payload_valid (out_stream.payload_valid),
  .field_end     (out_stream.field_end)
);
